>>> rtl/frame_rate_throttle_top_assert.svh
// Assertion macros shared by the checkers of frame_rate_throttle_top.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef FRAME_RATE_THROTTLE_TOP_ASSERT_SVH
`define FRAME_RATE_THROTTLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define FRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame_rate_throttle_top: assertion failed");

// Next-cycle implication.
`define FRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame_rate_throttle_top: assertion failed");

`endif

>>> rtl/frt_pkg.sv
package frt_pkg;

	localparam int unsigned PERIOD_W = 40;
	localparam int unsigned TOL_W    = 21;
	localparam int unsigned STAMP_W  = 64;
	localparam int unsigned NOW_W    = 63;
	localparam int unsigned CFG_IDX_W = 2;

	// late - deadline is at most 4*period + tolerance < 2^43
	localparam int unsigned DVD_W = 43;
	localparam int unsigned CNT_W = $clog2(DVD_W);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(66666667);
	localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(2000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD    = 2'd0,
		REG_TOLERANCE = 2'd1
	} frt_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM1,
		S_SUM2,
		S_SUM3,
		S_CMP,
		S_DIV,
		S_UPD1,
		S_UPD2,
		S_EMIT
	} frt_state_t;

endpackage

>>> rtl/frame_rate_throttle_top.sv
// Frame rate throttle: decides per frame whether to forward or drop it; a frame
// passes once its stamp plus tolerance reaches a deadline kept on a period grid.
// Input channel (in_valid/in_ready): one word carries capture_ns and now_ns.
// Output channel (out_valid/out_ready): one word per input, pass=1 forward.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 writes
// period_ns, 1 writes tolerance_ns (low 21 bits of cfg_data); other indexes
// are ignored. Write only while the block is idle.
// One shared 64-bit adder/subtractor is stepped by a small sequencer. The
// result word of a dropped frame is presented after the sum and compare steps;
// a passed frame first runs the bit-serial remainder loop (late - deadline)
// mod period that finds the new deadline, then updates the deadline.
// One frame is in flight at a time: in_ready is high only when the sequencer
// is idle, which it reaches as the result is presented, so a new word is
// taken only once the result of the last one is presented.
// The result sits in an output register; if the receiver stalls and a new
// result is ready, the sequencer holds until the register frees.
// Reset clears the deadline (unset), loads period 66666667 ns and tolerance
// 2000000 ns, and empties the output register.
module frame_rate_throttle_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [frt_pkg::STAMP_W-1:0]   capture_ns,
	input  logic [frt_pkg::NOW_W-1:0]     now_ns,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          pass,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [frt_pkg::PERIOD_W-1:0]  cfg_data
);
	import frt_pkg::*;

	frt_state_t state_q, state_d;

	logic [PERIOD_W-1:0] period_q;
	logic [TOL_W-1:0]    tol_q;
	logic [STAMP_W-1:0]  deadline_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [STAMP_W-1:0]  late_q;
	logic [STAMP_W-1:0]  tmp_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                restart_q;
	logic                res_q;
	logic                out_valid_q;
	logic                pass_q;

	logic [PERIOD_W-1:0] per_eff;
	logic                missing;
	logic [STAMP_W-1:0]  stamp_eff;
	logic                slot_free;
	logic [PERIOD_W:0]   trial;

	// shared adder/subtractor
	logic [STAMP_W-1:0]  alu_a, alu_b;
	logic                alu_sub;
	logic [STAMP_W:0]    alu_res;
	logic                alu_borrow;

	assign per_eff   = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign missing   = (capture_ns == '0) || capture_ns[STAMP_W-1];
	assign stamp_eff = missing ? {1'b0, now_ns} : capture_ns;
	assign slot_free = !out_valid_q || out_ready;
	assign trial     = {rem_q, dvd_q[DVD_W-1]};

	assign alu_res    = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
		+ (STAMP_W+1)'(alu_sub);
	assign alu_borrow = alu_sub && !alu_res[STAMP_W];

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pass      = pass_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		alu_a   = stamp_q;
		alu_b   = STAMP_W'(per_eff);
		alu_sub = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SUM1;
			end
			S_SUM1: begin
				state_d = S_SUM2;
			end
			S_SUM2: begin
				alu_a   = deadline_q;
				alu_b   = {{(STAMP_W-PERIOD_W-2){1'b0}}, per_eff, 2'b00};
				state_d = S_SUM3;
			end
			S_SUM3: begin
				alu_b   = STAMP_W'(tol_q);
				state_d = S_CMP;
			end
			S_CMP: begin
				alu_a   = late_q;
				alu_b   = deadline_q;
				alu_sub = 1'b1;
				state_d = alu_borrow ? S_EMIT : S_DIV;
			end
			S_DIV: begin
				alu_a   = STAMP_W'(trial);
				alu_sub = 1'b1;
				if (cnt_q == CNT_W'(DVD_W-1)) state_d = S_UPD1;
			end
			S_UPD1: begin
				alu_a   = late_q;
				alu_b   = STAMP_W'(rem_q);
				alu_sub = 1'b1;
				state_d = S_UPD2;
			end
			S_UPD2: begin
				alu_a   = tmp_q;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= PERIOD_RESET;
			tol_q       <= TOL_RESET;
			deadline_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_PERIOD:    period_q <= cfg_data;
					REG_TOLERANCE: tol_q    <= cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			// restart the deadline at the stamp when unset or far off
			if (state_q == S_SUM3 && restart_q) deadline_q <= stamp_q;
			if (state_q == S_UPD2) deadline_q <= alu_res[STAMP_W-1:0];
			if (state_q == S_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) stamp_q <= stamp_eff;
			end
			S_SUM1: begin
				restart_q <= (deadline_q == '0) || (alu_res[STAMP_W-1:0] < deadline_q);
			end
			S_SUM2: begin
				if (stamp_q > alu_res[STAMP_W-1:0]) restart_q <= 1'b1;
			end
			S_SUM3: begin
				late_q <= alu_res[STAMP_W-1:0];
			end
			S_CMP: begin
				res_q <= !alu_borrow;
				dvd_q <= alu_res[DVD_W-1:0];
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				// restoring step: keep the difference unless it borrowed
				rem_q <= alu_borrow ? trial[PERIOD_W-1:0] : alu_res[PERIOD_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_UPD1: begin
				tmp_q <= alu_res[STAMP_W-1:0];
			end
			S_EMIT: begin
				if (slot_free) pass_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/frt_checker.sv
module frt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pass
);
`include "frame_rate_throttle_top_assert.svh"

	// one frame in flight: busy right after taking a word
	`FRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a fresh result frees the input side at the same time
	`FRT_ASSERT_NOW(a_result_frees_input, $rose(out_valid), $rose(in_ready))

	// hold a stalled result
	`FRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pass))

endmodule

bind frame_rate_throttle_top frt_checker u_frt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pass      (pass)
);
